// ===== src/dilp_pkg.sv =====
// Shared types, constants and helper functions for the delimited integer list parser.
package dilp_pkg;

    localparam int MAX_VALUES = 1024;
    localparam int CNT_W      = (MAX_VALUES > 2) ? $clog2(MAX_VALUES) : 1;
    localparam int IDX_W      = 10;
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 7;
    localparam int PROD_W     = 36;
    localparam int TDATA_W    = 48;
    localparam int APB_AW     = 3;

    localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd44;
    localparam logic [CHAR_W-1:0] CH_NUL      = 8'd0;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
    localparam logic [CHAR_W-1:0] CH_PLUS     = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'd48;
    localparam logic [CHAR_W-1:0] CH_LOW_X    = 8'd120;
    localparam logic [CHAR_W-1:0] CH_UP_X     = 8'd88;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;

    localparam logic [APB_AW-1:0] ADDR_DELIM = 3'd0;

    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [2:0] {
        PH_WS,
        PH_SIGN,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_OCT,
        RX_HEX
    } radix_t;

    typedef struct packed {
        phase_t               phase;
        logic                 neg;
        radix_t               radix;
        logic [VALUE_W-1:0]   acc;
        logic                 range_err;
    } tok_state_t;

    localparam tok_state_t TOK_CLEAR = '{
        phase:     PH_WS,
        neg:       1'b0,
        radix:     RX_DEC,
        acc:       '0,
        range_err: 1'b0
    };

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = DIGIT_NONE;
        if (c inside {[8'd48:8'd57]}) begin
            d = DIGIT_W'(c - 8'd48);
        end else if (c inside {[8'd97:8'd122]}) begin
            d = DIGIT_W'(c - 8'd87);
        end else if (c inside {[8'd65:8'd90]}) begin
            d = DIGIT_W'(c - 8'd55);
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == 8'd32) || (c inside {[8'd9:8'd13]});
    endfunction

endpackage

// ===== src/delimited_integer_list_parser.sv =====
// A result is registered as the delimiter or terminator leaves the input register.
// Throughput: one character item per cycle unless m_tready holds a result back; the input
// register and the result register let the next item in while a result waits for m_tready.
// Each character goes through one registered conversion step (shift-add of radix 8/10/16).
// Reset (aresetn low, synchronous): token state, value index and both valid flags clear;
// the delimiter returns to ','.
module delimited_integer_list_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dilp_pkg::APB_AW-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dilp_pkg::CHAR_W-1:0]         s_tdata,   // [7:0] ch
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dilp_pkg::TDATA_W-1:0]        m_tdata,   // [31:0] value, [41:32] value_index,
                                                           // [42] overflowed, [47:43] zero
    output logic                                m_tlast    // line_done
);

    logic [dilp_pkg::CHAR_W-1:0]   delim;

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [dilp_pkg::CHAR_W-1:0]   ch_reg;

    dilp_pkg::tok_state_t          tok_reg;
    dilp_pkg::tok_state_t          tok_next;
    dilp_pkg::tok_state_t          fed;
    logic                          in_token_reg;
    logic                          in_token_next;
    logic [dilp_pkg::CNT_W-1:0]    cnt_reg;
    logic [dilp_pkg::CNT_W-1:0]    cnt_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [dilp_pkg::VALUE_W-1:0]  value_reg;
    logic [dilp_pkg::IDX_W-1:0]    index_reg;
    logic                          done_reg;
    logic                          ovf_reg;

    logic                          proc_fire;
    logic                          is_term;
    logic                          is_delim;
    logic                          emit;
    logic [dilp_pkg::VALUE_W-1:0]  emit_value;
    logic [dilp_pkg::CNT_W+dilp_pkg::IDX_W-1:0] cnt_ext;

    dilp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .delim   (delim)
    );

    dilp_feed u_feed (
        .ch  (ch_reg),
        .cur (tok_reg),
        .nxt (fed)
    );

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    assign is_term  = (ch_reg == dilp_pkg::CH_NUL) || (ch_reg == dilp_pkg::CH_LF);
    assign is_delim = (ch_reg == delim);
    assign emit     = proc_fire && in_token_reg && (is_term || is_delim);

    always_comb begin
        if (tok_reg.range_err) begin
            emit_value = tok_reg.neg ? dilp_pkg::NEG_LIMIT : dilp_pkg::POS_LIMIT;
        end else if (tok_reg.neg) begin
            emit_value = '0 - tok_reg.acc;
        end else begin
            emit_value = tok_reg.acc;
        end
    end

    assign cnt_ext = {{dilp_pkg::IDX_W{1'b0}}, cnt_reg};

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        tok_next      = tok_reg;
        in_token_next = in_token_reg;
        cnt_next      = cnt_reg;
        if (proc_fire) begin
            if (is_term) begin
                tok_next      = dilp_pkg::TOK_CLEAR;
                in_token_next = 1'b0;
                cnt_next      = '0;
            end else if (is_delim) begin
                tok_next      = dilp_pkg::TOK_CLEAR;
                in_token_next = 1'b0;
                if (in_token_reg) begin
                    // wrap the index after the last slot of a line
                    if (cnt_reg == dilp_pkg::CNT_W'(dilp_pkg::MAX_VALUES - 1)) begin
                        cnt_next = '0;
                    end else begin
                        cnt_next = cnt_reg + dilp_pkg::CNT_W'(1);
                    end
                end
            end else begin
                tok_next      = fed;
                in_token_next = 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            tok_reg       <= dilp_pkg::TOK_CLEAR;
            in_token_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            tok_reg       <= tok_next;
            in_token_reg  <= in_token_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg <= s_tdata;
        end
        if (emit) begin
            value_reg <= emit_value;
            index_reg <= cnt_ext[dilp_pkg::IDX_W-1:0];
            done_reg  <= is_term;
            ovf_reg   <= tok_reg.range_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = done_reg;
    assign m_tdata  = {{(dilp_pkg::TDATA_W - dilp_pkg::VALUE_W - dilp_pkg::IDX_W - 1){1'b0}},
                       ovf_reg, index_reg, value_reg};

endmodule

// ===== src/dilp_cfg.sv =====
// APB register file holding the delimiter character.
module dilp_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dilp_pkg::APB_AW-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic [dilp_pkg::CHAR_W-1:0]         delim
);

    logic [dilp_pkg::CHAR_W-1:0] delim_reg;
    logic [dilp_pkg::CHAR_W-1:0] delim_next;

    assign pready = 1'b1;

    always_comb begin
        delim_next = delim_reg;
        if (psel && penable && pwrite && pready && (paddr == dilp_pkg::ADDR_DELIM)) begin
            delim_next = pwdata[dilp_pkg::CHAR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= dilp_pkg::DELIM_RESET;
        end else begin
            delim_reg <= delim_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == dilp_pkg::ADDR_DELIM) begin
            prdata = {{(32 - dilp_pkg::CHAR_W){1'b0}}, delim_reg};
        end
    end

    assign delim = delim_reg;

endmodule

// ===== src/dilp_feed.sv =====
// Per-character conversion step: whitespace, sign, radix prefix and digit accumulation.
module dilp_feed (
    input  logic [dilp_pkg::CHAR_W-1:0] ch,
    input  dilp_pkg::tok_state_t        cur,
    output dilp_pkg::tok_state_t        nxt
);

    logic [dilp_pkg::DIGIT_W-1:0] d;
    logic [dilp_pkg::DIGIT_W-1:0] radix_val;
    logic [dilp_pkg::PROD_W-1:0]  acc_ext;
    logic [dilp_pkg::PROD_W-1:0]  scaled;
    logic [dilp_pkg::PROD_W-1:0]  sum;
    logic [dilp_pkg::PROD_W-1:0]  limit;
    logic                         first_digit;

    assign d       = dilp_pkg::digit_of(ch);
    assign acc_ext = {{(dilp_pkg::PROD_W - dilp_pkg::VALUE_W){1'b0}}, cur.acc};
    assign limit   = cur.neg
                   ? {{(dilp_pkg::PROD_W - dilp_pkg::VALUE_W){1'b0}}, dilp_pkg::NEG_LIMIT}
                   : {{(dilp_pkg::PROD_W - dilp_pkg::VALUE_W){1'b0}}, dilp_pkg::POS_LIMIT};

    always_comb begin
        case (cur.radix)
            dilp_pkg::RX_OCT: begin
                radix_val = 7'd8;
                scaled    = acc_ext << 3;
            end
            dilp_pkg::RX_HEX: begin
                radix_val = 7'd16;
                scaled    = acc_ext << 4;
            end
            default: begin
                radix_val = 7'd10;
                scaled    = (acc_ext << 3) + (acc_ext << 1);
            end
        endcase
    end

    assign sum = scaled + {{(dilp_pkg::PROD_W - dilp_pkg::DIGIT_W){1'b0}}, d};

    always_comb begin
        nxt         = cur;
        first_digit = 1'b0;
        case (cur.phase)
            dilp_pkg::PH_WS: begin
                if (dilp_pkg::is_space(ch)) begin
                    nxt = cur;
                end else if ((ch == dilp_pkg::CH_PLUS) || (ch == dilp_pkg::CH_MINUS)) begin
                    nxt.neg   = (ch == dilp_pkg::CH_MINUS);
                    nxt.phase = dilp_pkg::PH_SIGN;
                end else begin
                    first_digit = 1'b1;
                end
            end
            dilp_pkg::PH_SIGN: begin
                first_digit = 1'b1;
            end
            dilp_pkg::PH_ZERO: begin
                if ((ch == dilp_pkg::CH_LOW_X) || (ch == dilp_pkg::CH_UP_X)) begin
                    nxt.phase = dilp_pkg::PH_HEXPFX;
                end else if (d < 7'd8) begin
                    nxt.radix = dilp_pkg::RX_OCT;
                    nxt.acc   = {{(dilp_pkg::VALUE_W - dilp_pkg::DIGIT_W){1'b0}}, d};
                    nxt.phase = dilp_pkg::PH_DIGITS;
                end else begin
                    nxt.phase = dilp_pkg::PH_STOP;
                end
            end
            dilp_pkg::PH_HEXPFX: begin
                if (d < 7'd16) begin
                    nxt.radix = dilp_pkg::RX_HEX;
                    nxt.acc   = {{(dilp_pkg::VALUE_W - dilp_pkg::DIGIT_W){1'b0}}, d};
                    nxt.phase = dilp_pkg::PH_DIGITS;
                end else begin
                    nxt.phase = dilp_pkg::PH_STOP;
                end
            end
            dilp_pkg::PH_DIGITS: begin
                if (d < radix_val) begin
                    // once saturated, swallow the remaining digits
                    if (!cur.range_err) begin
                        if (sum > limit) begin
                            nxt.range_err = 1'b1;
                        end else begin
                            nxt.acc = sum[dilp_pkg::VALUE_W-1:0];
                        end
                    end
                end else begin
                    nxt.phase = dilp_pkg::PH_STOP;
                end
            end
            default: begin
                nxt.phase = dilp_pkg::PH_STOP;
            end
        endcase

        if (first_digit) begin
            if (ch == dilp_pkg::CH_ZERO) begin
                nxt.phase = dilp_pkg::PH_ZERO;
            end else if ((d >= 7'd1) && (d <= 7'd9)) begin
                nxt.radix = dilp_pkg::RX_DEC;
                nxt.acc   = {{(dilp_pkg::VALUE_W - dilp_pkg::DIGIT_W){1'b0}}, d};
                nxt.phase = dilp_pkg::PH_DIGITS;
            end else begin
                nxt.phase = dilp_pkg::PH_STOP;
            end
        end
    end

endmodule

// ===== bench/dilp_value_checker.sv =====
// Checker for the delimited integer list parser: predicts parsed values and compares results.
module dilp_value_checker
    import dilp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [CHAR_W-1:0]    s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [TDATA_W-1:0]   m_tdata,
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   index;
        logic               done;
        logic               ovf;
    } parsed_value_t;

    parsed_value_t expected_values[$];

    // predictor state
    logic [CHAR_W-1:0]  delim;
    logic               tok_open;
    phase_t             phase;
    logic               neg;
    radix_t             radix;
    logic [VALUE_W-1:0] mag;
    logic               ovf;
    int unsigned        val_count;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int unsigned char_digit(input logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "z") return c - "a" + 10;
        if (c >= "A" && c <= "Z") return c - "A" + 10;
        return 99;
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic int unsigned radix_base(input radix_t r);
        case (r)
            RX_OCT:  return 8;
            RX_HEX:  return 16;
            default: return 10;
        endcase
    endfunction

    task automatic clear_token();
        tok_open = 1'b0;
        phase    = PH_WS;
        neg      = 1'b0;
        radix    = RX_DEC;
        mag      = '0;
        ovf      = 1'b0;
    endtask

    task automatic start_digits(input radix_t r, input int unsigned d);
        radix = r;
        mag   = VALUE_W'(d);
        phase = PH_DIGITS;
    endtask

    task automatic close_token(input logic done);
        parsed_value_t v;
        if (ovf) v.value = neg ? NEG_LIMIT : POS_LIMIT;
        else     v.value = neg ? -mag : mag;
        v.index = IDX_W'(val_count);
        v.done  = done;
        v.ovf   = ovf;
        expected_values.push_back(v);
    endtask

    task automatic feed_char(input logic [CHAR_W-1:0] c);
        int unsigned d;
        int unsigned base;
        logic [63:0] n;
        logic [63:0] limit;
        d    = char_digit(c);
        base = radix_base(radix);
        case (phase)
            PH_WS, PH_SIGN: begin
                if (!(phase == PH_WS && is_blank(c))) begin
                    if (phase == PH_WS && (c == CH_PLUS || c == CH_MINUS)) begin
                        neg   = (c == CH_MINUS);
                        phase = PH_SIGN;
                    end else if (c == CH_ZERO) begin
                        phase = PH_ZERO;
                    end else if (d >= 1 && d <= 9) begin
                        start_digits(RX_DEC, d);
                    end else begin
                        phase = PH_STOP;
                    end
                end
            end
            PH_ZERO: begin
                if (c == CH_LOW_X || c == CH_UP_X) phase = PH_HEXPFX;
                else if (d < 8) start_digits(RX_OCT, d);
                else phase = PH_STOP;
            end
            PH_HEXPFX: begin
                if (d < 16) start_digits(RX_HEX, d);
                else phase = PH_STOP;
            end
            PH_DIGITS: begin
                if (d < base) begin
                    // once saturated, swallow the remaining digits
                    if (!ovf) begin
                        limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                        n = 64'(mag) * base + d;
                        if (n > limit) ovf = 1'b1;
                        else mag = n[VALUE_W-1:0];
                    end
                end else begin
                    phase = PH_STOP;
                end
            end
            default: phase = PH_STOP;
        endcase
    endtask

    task automatic step_char(input logic [CHAR_W-1:0] c);
        if (c == CH_NUL || c == CH_LF) begin
            if (tok_open) close_token(1'b1);
            clear_token();
            val_count = 0;
        end else if (c == delim) begin
            if (tok_open) begin
                close_token(1'b0);
                val_count++;
                if (val_count >= MAX_VALUES) val_count = 0;
            end
            clear_token();
        end else begin
            tok_open = 1'b1;
            feed_char(c);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        parsed_value_t want;
        if (!aresetn) begin
            delim = DELIM_RESET;
            clear_token();
            val_count = 0;
            expected_values.delete();
        end else begin
            // compare before pushing: a result never belongs to this edge's item
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    $error("unexpected value %0h at index %0d", m_tdata[31:0], m_tdata[41:32]);
                    fail_count++;
                end else begin
                    want = expected_values.pop_front();
                    check_field("value", want.value, m_tdata[31:0]);
                    check_field("value_index", 32'(want.index), 32'(m_tdata[41:32]));
                    check_field("line_done", 32'(want.done), 32'(m_tlast));
                    check_field("overflowed", 32'(want.ovf), 32'(m_tdata[42]));
                end
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_DELIM)
                delim = pwdata[CHAR_W-1:0];
            if (s_tvalid && s_tready)
                step_char(s_tdata);
        end
        pending = expected_values.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the parser testbench: clock, reset, register writes, character stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dilp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;

    int                  fail_count;
    int                  pending;
    int unsigned         cycles = 0;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_stall_pct = 0;
    logic [CHAR_W-1:0]   cur_delim = DELIM_RESET;
    logic [CHAR_W-1:0]   line_q[$];

    // values at the edges of the 32-bit range in every radix, plus zeros and digitless tokens
    string extreme_toks[] = '{
        "2147483647", "2147483648", "-2147483648", "-2147483649", "0x7fffffff",
        "0X80000000", "-0x80000000", "-0x80000001", "017777777777", "020000000000",
        "-020000000000", "0xFFFFFFFFF", "99999999999999", "+0", "-0", "0x", "-", "+"
    };

    delimited_integer_list_parser dut (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

    dilp_value_checker u_checker (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .fail_count, .pending
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_char(input logic [CHAR_W-1:0] c);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_str(input string s);
        foreach (s[i]) send_char(s[i]);
    endtask

    // hold the input until every expected value has come out
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_str(input string s);
        foreach (s[i]) line_q.push_back(s[i]);
    endtask

    task automatic push_token();
        int unsigned sign_sel;
        int unsigned radix_pick;
        int unsigned ndig;
        int unsigned d;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 3)) line_q.push_back(CHAR_W'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                d = $urandom_range(0, 4);
                line_q.push_back(d == 0 ? 8'd32 : (d == 1 ? 8'd9 : CHAR_W'(d + 9)));
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            push_str(extreme_toks[$urandom_range(0, extreme_toks.size() - 1)]);
            return;
        end
        sign_sel = $urandom_range(0, 3);
        if (sign_sel == 1) line_q.push_back(CH_PLUS);
        if (sign_sel == 2) line_q.push_back(CH_MINUS);
        radix_pick = $urandom_range(0, 2);
        if (radix_pick != 0) line_q.push_back(CH_ZERO);
        if (radix_pick == 2) line_q.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
        d = $urandom_range(0, 19);
        ndig = (d == 0) ? 0 : (d < 4 ? $urandom_range(8, 14) : $urandom_range(1, 6));
        for (int i = 0; i < ndig; i++) begin
            case (radix_pick)
                0: d = (i == 0) ? $urandom_range(1, 9) : $urandom_range(0, 9);
                1: d = $urandom_range(0, 7);
                default: d = $urandom_range(0, 15);
            endcase
            if (d < 10) line_q.push_back(CHAR_W'("0" + d));
            else line_q.push_back(CHAR_W'(($urandom_range(0, 1) ? "a" : "A") + d - 10));
        end
        if ($urandom_range(0, 9) == 0) line_q.push_back(CHAR_W'($urandom_range(33, 126)));
    endtask

    task automatic send_line(inout int unsigned sent);
        int unsigned ntok;
        int unsigned t;
        line_q.delete();
        ntok = $urandom_range(0, 6);
        if ($urandom_range(0, 4) == 0) line_q.push_back(cur_delim);
        for (int i = 0; i < ntok; i++) begin
            push_token();
            repeat ($urandom_range(0, 4) == 0 ? $urandom_range(2, 3) : 1)
                line_q.push_back(cur_delim);
        end
        if (ntok != 0 && $urandom_range(0, 1)) push_token();
        t = $urandom_range(0, 19);
        if (t < 9) line_q.push_back(CH_LF);
        else if (t < 18) line_q.push_back(CH_NUL);
        foreach (line_q[i]) send_char(line_q[i]);
        sent += line_q.size();
    endtask

    initial begin
        logic [CHAR_W-1:0] delim_set[8];
        int unsigned sent;
        delim_set = '{8'd44, 8'd0, 8'd255, 8'd32, 8'd53, 8'd10, 8'd59, 8'd0};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // tokens without digits, positive saturation, the most negative value, empty terminator
        send_str(" ,,-,0x,99999999999,-0x80000000,7z");
        send_char(CH_LF);
        send_char(CH_NUL);
        send_str("\t+017,");
        send_char(8'hFF);
        send_char(CH_LF);

        // index wraps after the largest count of values in one line
        repeat (MAX_VALUES + 1) send_str("7,");
        send_str("8");
        send_char(CH_LF);

        for (int p = 0; p < 8; p++) begin
            wait_drain();
            cur_delim = (p == 7) ? CHAR_W'($urandom_range(0, 255)) : delim_set[p];
            apb_write(ADDR_DELIM, {24'($urandom), cur_delim});
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (p == 1) begin
                // pause inside an open token until the output is empty
                send_str(" -4");
                wait_drain();
                send_str("56");
                send_char(CH_LF);
            end
            sent = 0;
            while (sent < 40) send_line(sent);
        end

        wait_drain();
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
